// ----- design/efps_pkg.sv -----
package efps_pkg;

    localparam int MAX_PROCESSORS_DEF = 64;
    localparam int TIME_WIDTH_DEF     = 48;

    localparam int DURATION_WIDTH   = 32;
    localparam int START_WIDTH      = 48;
    localparam int INDEX_OUT_WIDTH  = 6;
    localparam int NUM_PROC_WIDTH   = 7;
    localparam int APB_ADDR_WIDTH   = 3;
    localparam int APB_DATA_WIDTH   = 32;

    localparam logic [NUM_PROC_WIDTH-1:0] NUM_PROC_RESET = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_NUM_PROCESSORS = 1'b0;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SIFT
    } state_t;

endpackage

// ----- design/efps_heap_ram.sv -----
module efps_heap_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 54
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr0,
    input  logic [AW-1:0] raddr1,
    output logic [DW-1:0] rdata0,
    output logic [DW-1:0] rdata1
);

    logic [DW-1:0] mem [0:DEPTH-1];
    logic [DW-1:0] rdata0_reg;
    logic [DW-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

// ----- design/earliest_free_processor_scheduler_unit.sv -----
// earliest-free processor scheduler
//
// task channel (task_valid/task_stall) carries one word per task: a duration
// and a last_task mark. result channel (result_valid/result_stall) returns one
// word per task: the processor that was free earliest (lowest index on ties),
// the task start time, a saturation flag and the echoed last mark.
// free times live in a min-heap held in a two-read one-write ram; the root is
// cached in a register so the result is formed in the accept cycle and
// registered, showing up on the result port in the cycle after.
// after accept the new free time is sifted down from the root, one heap level
// per cycle, comparing the two children and then the smaller one with the new
// key; the block takes no new task until the sift has ended.
// a task with last_task set, a write of num_processors, and reset each start
// a clearing pass that loads n heap entries, one per cycle (n is 64 after
// reset at the default size); no task is taken meanwhile, apb writes still are.
// while the result register holds an untaken word, task_stall stays high;
// a stalled result word holds its value.
module earliest_free_processor_scheduler_unit
    import efps_pkg::*;
#(
    parameter int MAX_PROCESSORS = MAX_PROCESSORS_DEF,
    parameter int TIME_WIDTH     = TIME_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [APB_DATA_WIDTH-1:0]   pwdata,
    output logic [APB_DATA_WIDTH-1:0]   prdata,
    output logic                        pready,

    input  logic                        task_valid,
    output logic                        task_stall,
    input  logic [DURATION_WIDTH-1:0]   duration,
    input  logic                        last_task,

    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [INDEX_OUT_WIDTH-1:0]  processor_index,
    output logic [START_WIDTH-1:0]      task_start,
    output logic                        saturated,
    output logic                        last_result
);

    localparam int IW  = (MAX_PROCESSORS > 1) ? $clog2(MAX_PROCESSORS) : 1;
    localparam int CW  = $clog2(MAX_PROCESSORS + 1);
    localparam int EW  = TIME_WIDTH + IW;
    localparam int AW  = IW + 2;
    localparam int GW  = (AW > CW) ? AW : CW;
    localparam int KW  = (CW > NUM_PROC_WIDTH) ? CW : NUM_PROC_WIDTH;
    localparam int IXW = (IW > INDEX_OUT_WIDTH) ? IW : INDEX_OUT_WIDTH;
    localparam int SXW = (TIME_WIDTH > START_WIDTH) ? TIME_WIDTH : START_WIDTH;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    state_t                      state_reg, state_next;
    logic [IW-1:0]               i_reg, i_next;
    logic [IW-1:0]               clr_reg, clr_next;
    logic [EW-1:0]               x_reg, x_next;
    logic [EW-1:0]               root_reg, root_next;
    logic [NUM_PROC_WIDTH-1:0]   num_proc_reg, num_proc_next;

    logic                        res_valid_reg, res_valid_next;
    logic [INDEX_OUT_WIDTH-1:0]  res_index_reg, res_index_next;
    logic [START_WIDTH-1:0]      res_start_reg, res_start_next;
    logic                        res_sat_reg, res_sat_next;
    logic                        res_last_reg, res_last_next;

    logic                        cfg_write;
    logic                        task_acc;

    logic [KW-1:0]               np_ext;
    logic [CW-1:0]               count;
    logic [GW-1:0]               n_ext;

    logic [TIME_WIDTH-1:0]       root_time;
    logic [IW-1:0]               root_idx;
    logic [TIME_WIDTH:0]         sum;
    logic                        sat;
    logic [TIME_WIDTH-1:0]       fin_time;
    logic [SXW-1:0]              st_ext;
    logic [IXW-1:0]              ix_ext;

    logic [GW-1:0]               l_ext, r_ext;
    logic                        l_ok, r_ok, pick_r, descend;
    logic [EW-1:0]               cand;
    logic [IW-1:0]               cand_addr;
    logic [IW-1:0]               rd_base;
    logic [IW:0]                 la, lb;

    logic                        we;
    logic [IW-1:0]               waddr;
    logic [EW-1:0]               wdata;
    logic [IW-1:0]               raddr0, raddr1;
    logic [EW-1:0]               rdata0, rdata1;

    efps_heap_ram #(
        .DEPTH (MAX_PROCESSORS),
        .AW    (IW),
        .DW    (EW)
    ) u_heap (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    // apb side
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_NUM_PROCESSORS);
    assign prdata    = (paddr[2] == REG_NUM_PROCESSORS) ?
                       APB_DATA_WIDTH'(num_proc_reg) : '0;

    always_comb
    begin
        num_proc_next = num_proc_reg;
        if (cfg_write)
        begin
            num_proc_next = pwdata[NUM_PROC_WIDTH-1:0];
        end
    end

    // processors in use, zero treated as one, clamped to the heap size
    assign np_ext = KW'(num_proc_reg);
    always_comb
    begin
        if (np_ext == '0)
        begin
            count = CW'(1);
        end
        else if (np_ext > KW'(MAX_PROCESSORS))
        begin
            count = CW'(MAX_PROCESSORS);
        end
        else
        begin
            count = CW'(np_ext);
        end
    end
    assign n_ext = GW'(count);

    // result of the root
    assign root_time = root_reg[EW-1:IW];
    assign root_idx  = root_reg[IW-1:0];
    assign sum       = {1'b0, root_time} + (TIME_WIDTH+1)'(duration);
    assign sat       = (sum >= {1'b0, TIME_MAX});
    assign fin_time  = sat ? TIME_MAX : sum[TIME_WIDTH-1:0];
    assign st_ext    = SXW'(root_time);
    assign ix_ext    = IXW'(root_idx);

    assign task_stall = (state_reg != S_IDLE) || (res_valid_reg && result_stall);
    assign task_acc   = task_valid && !task_stall;

    // children of the hole, keys compared as {time, index}
    assign l_ext     = GW'({i_reg, 1'b1});
    assign r_ext     = l_ext + GW'(1);
    assign l_ok      = (l_ext < n_ext);
    assign r_ok      = (r_ext < n_ext);
    assign pick_r    = r_ok && (rdata1 < rdata0);
    assign cand      = pick_r ? rdata1 : rdata0;
    assign cand_addr = pick_r ? r_ext[IW-1:0] : l_ext[IW-1:0];
    assign descend   = l_ok && (cand < x_reg);

    // children of the next hole are fetched while this level resolves
    assign rd_base = (state_reg == S_SIFT) ? cand_addr : '0;
    assign la      = {rd_base, 1'b1};
    assign lb      = la + (IW+1)'(1);
    assign raddr0  = la[IW-1:0];
    assign raddr1  = lb[IW-1:0];

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        clr_next   = clr_reg;
        x_next     = x_reg;
        root_next  = root_reg;
        we         = 1'b0;
        waddr      = i_reg;
        wdata      = x_reg;

        case (state_reg)
            S_CLEAR:
            begin
                we        = 1'b1;
                waddr     = clr_reg;
                wdata     = {{TIME_WIDTH{1'b0}}, clr_reg};
                root_next = '0;
                if ((GW'(clr_reg) + GW'(1)) == n_ext)
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IW'(1);
                end
            end
            S_IDLE:
            begin
                if (task_acc)
                begin
                    x_next = {fin_time, root_idx};
                    i_next = '0;
                    if (last_task)
                    begin
                        clr_next   = '0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_SIFT;
                    end
                end
            end
            S_SIFT:
            begin
                we    = 1'b1;
                waddr = i_reg;
                if (descend)
                begin
                    wdata  = cand;
                    i_next = cand_addr;
                end
                else
                begin
                    wdata      = x_reg;
                    state_next = S_IDLE;
                end
                if (i_reg == '0)
                begin
                    root_next = wdata;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase

        // a new processor count reloads the heap
        if (cfg_write)
        begin
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    // result word register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_index_next = res_index_reg;
        res_start_next = res_start_reg;
        res_sat_next   = res_sat_reg;
        res_last_next  = res_last_reg;
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (task_acc)
        begin
            res_valid_next = 1'b1;
            res_index_next = ix_ext[INDEX_OUT_WIDTH-1:0];
            res_start_next = st_ext[START_WIDTH-1:0];
            res_sat_next   = sat;
            res_last_next  = last_task;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            num_proc_reg  <= NUM_PROC_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            num_proc_reg  <= num_proc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        x_reg         <= x_next;
        root_reg      <= root_next;
        res_index_reg <= res_index_next;
        res_start_reg <= res_start_next;
        res_sat_reg   <= res_sat_next;
        res_last_reg  <= res_last_next;
    end

    assign result_valid    = res_valid_reg;
    assign processor_index = res_index_reg;
    assign task_start      = res_start_reg;
    assign saturated       = res_sat_reg;
    assign last_result     = res_last_reg;

    a_last_reloads: assert property (@(posedge clk) disable iff (!rst_n)
        (task_acc && last_task && !cfg_write) |=> (state_reg == S_CLEAR))
        else $error("last task did not start a reload");

    a_result_from_task: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(task_acc))
        else $error("result word without an accepted task");

    a_hole_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIFT) |-> (GW'(i_reg) < n_ext))
        else $error("sift position beyond heap");

    a_clear_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (GW'(clr_reg) < n_ext))
        else $error("clearing pass beyond heap");

    a_root_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIFT && i_reg == '0 && !cfg_write) |=> (root_reg == $past(wdata)))
        else $error("cached root differs from heap root");

endmodule
